// ===== rtl/bwfc_pkg.sv =====
// Shared types, constants and helpers for the binary-weight fully connected layer.
// Used by bwfc_ctrl, bwfc_datapath and binary_weight_fc_forward_top. No dependencies.
package bwfc_pkg;

   localparam int OUT_DIM_DEFAULT = 64;
   localparam int IN_DIM_DEFAULT  = 1024;

   localparam int UNIT_W     = 6;
   localparam int FEAT_W     = 10;
   localparam int VALUE_W    = 16;
   localparam int SUM_W      = 32;
   localparam int AIN_W      = 11;
   localparam int AOUT_W     = 7;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 1;

   localparam logic [AIN_W-1:0]  AIN_RESET  = AIN_W'(1024);
   localparam logic [AOUT_W-1:0] AOUT_RESET = AOUT_W'(64);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_INPUTS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_OUTPUTS = 1'b1;

   // action codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_DATA = 1'b1;

   typedef struct packed {
      logic              accept;     // input word taken this cycle
      logic              emit;       // load output register with one unit
      logic [UNIT_W-1:0] emit_unit;
      logic              emit_last;
      logic              clear_acc;  // zero every accumulator
   } ctrl_cmd_type;

   typedef struct packed {
      logic              last_pending; // final feature of a vector in the accumulate stage
      logic              out_free;     // output register can take a word this cycle
      logic [AOUT_W-1:0] n_out;        // clamped active output count
   } dp_status_type;

   // saturating 32-bit add of a 17-bit signed step
   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0]   acc,
      input logic signed [VALUE_W:0]   delta
   );
      logic signed [SUM_W:0] s;
      s = {acc[SUM_W-1], acc} + {{(SUM_W-VALUE_W){delta[VALUE_W]}}, delta};
      if (s[SUM_W] != s[SUM_W-1]) begin
         sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sat_add = s[SUM_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/bwfc_ctrl.sv =====
// Controller for the binary-weight FC layer: run / drain state machine and unit counter.
// Depends on bwfc_pkg; drives bwfc_datapath through ctrl_cmd_type.
module bwfc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bwfc_pkg::dp_status_type status_i,
   output bwfc_pkg::ctrl_cmd_type  cmd_o
);
   import bwfc_pkg::*;

   typedef enum logic {ST_RUN, ST_DRAIN} state_type;

   state_type         state_ff, state_in;
   logic [UNIT_W-1:0] unit_ff, unit_in;
   logic              unit_last;

   assign unit_last = ({1'b0, unit_ff} == (status_i.n_out - AOUT_W'(1)));

   always_comb begin
      state_in        = state_ff;
      unit_in         = unit_ff;
      req_ready       = 1'b0;
      cmd_o           = '0;
      cmd_o.emit_unit = unit_ff;
      cmd_o.emit_last = unit_last;
      case (state_ff)
         ST_RUN: begin
            // hold input while the closing feature is being accumulated
            req_ready    = !status_i.last_pending;
            cmd_o.accept = req_valid && req_ready;
            if (status_i.last_pending) begin
               state_in = ST_DRAIN;
               unit_in  = '0;
            end
         end
         ST_DRAIN: begin
            if (status_i.out_free) begin
               cmd_o.emit = 1'b1;
               if (unit_last) begin
                  cmd_o.clear_acc = 1'b1;
                  state_in        = ST_RUN;
               end else begin
                  unit_in = unit_ff + UNIT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         unit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         unit_ff  <= unit_in;
      end
   end

endmodule

// ===== rtl/bwfc_datapath.sv =====
// Datapath for the binary-weight FC layer: config registers, sign memory, accumulators
// and output register. Depends on bwfc_pkg; commanded by bwfc_ctrl.
module bwfc_datapath #(
   parameter int OUT_DIM = bwfc_pkg::OUT_DIM_DEFAULT,
   parameter int IN_DIM  = bwfc_pkg::IN_DIM_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [bwfc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bwfc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  req_action,
   input  logic [bwfc_pkg::UNIT_W-1:0]           req_unit_index,
   input  logic [bwfc_pkg::FEAT_W-1:0]           req_feature_index,
   input  logic signed [bwfc_pkg::VALUE_W-1:0]   req_value,
   input  bwfc_pkg::ctrl_cmd_type                cmd_i,
   output bwfc_pkg::dp_status_type               status_o,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [bwfc_pkg::UNIT_W-1:0]           rsp_out_unit,
   output logic signed [bwfc_pkg::SUM_W-1:0]     rsp_out_sum,
   output logic                                  rsp_out_last
);
   import bwfc_pkg::*;

   localparam int AW  = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
   localparam int UIW = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
   localparam int NW  = $clog2(IN_DIM + 1);
   localparam int CW  = (NW > AIN_W) ? NW : AIN_W;
   localparam int EW  = (AW > FEAT_W) ? AW : FEAT_W;

   // configuration
   logic [AIN_W-1:0]  ain_ff;
   logic [AOUT_W-1:0] aout_ff;
   logic [CW-1:0]     ain_ext, n_in;
   logic [AOUT_W-1:0] n_out;

   // decode
   logic [CW-1:0]     feat_cmp;
   logic [EW-1:0]     feat_ext;
   logic [AW-1:0]     mem_addr;
   logic [UIW-1:0]    unit_sel;
   logic              load_we, data_ok, data_last;

   // storage
   logic [OUT_DIM-1:0]             sign_mem [IN_DIM];
   logic [OUT_DIM-1:0]             sign_rd_ff;
   logic                           stage_valid_ff, stage_last_ff;
   logic signed [VALUE_W-1:0]      stage_value_ff;
   logic signed [SUM_W-1:0]        acc_ff [OUT_DIM];
   logic                           rsp_valid_ff;
   logic [UNIT_W-1:0]              rsp_unit_ff;
   logic signed [SUM_W-1:0]        rsp_sum_ff;
   logic                           rsp_last_ff;
   logic signed [VALUE_W:0]        val_pos, val_neg;

   always_ff @(posedge clock) begin
      if (reset) begin
         ain_ff  <= AIN_RESET;
         aout_ff <= AOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE_INPUTS:  ain_ff  <= csr_wdata[AIN_W-1:0];
            CSR_ACTIVE_OUTPUTS: aout_ff <= csr_wdata[AOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp counts to 1..IN_DIM and 1..OUT_DIM
   assign ain_ext = CW'(ain_ff);
   assign n_in    = (ain_ext == '0) ? CW'(1) :
                    (ain_ext > CW'(IN_DIM)) ? CW'(IN_DIM) : ain_ext;
   assign n_out   = (aout_ff == '0) ? AOUT_W'(1) :
                    (aout_ff > AOUT_W'(OUT_DIM)) ? AOUT_W'(OUT_DIM) : aout_ff;

   assign feat_cmp  = CW'(req_feature_index);
   assign feat_ext  = EW'(req_feature_index);
   assign mem_addr  = feat_ext[AW-1:0];
   assign unit_sel  = req_unit_index[UIW-1:0];
   assign load_we   = cmd_i.accept && (req_action == ACT_LOAD)
                      && ({1'b0, req_unit_index} < (UNIT_W+1)'(OUT_DIM))
                      && (feat_cmp < CW'(IN_DIM));
   assign data_ok   = cmd_i.accept && (req_action == ACT_DATA) && (feat_cmp < n_in);
   assign data_last = (feat_cmp == (n_in - CW'(1)));

   // sign memory: bit set means negative weight
   always_ff @(posedge clock) begin
      if (load_we) begin
         sign_mem[mem_addr][unit_sel] <= req_value[VALUE_W-1];
      end
      if (data_ok) begin
         sign_rd_ff <= sign_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= data_ok;
      end
      if (data_ok) begin
         stage_last_ff  <= data_last;
         stage_value_ff <= req_value;
      end
   end

   assign val_pos = {stage_value_ff[VALUE_W-1], stage_value_ff};
   assign val_neg = -val_pos;

   // one saturating add/subtract lane per output unit
   for (genvar u = 0; u < OUT_DIM; u++) begin : g_lane
      always_ff @(posedge clock) begin
         if (reset || cmd_i.clear_acc) begin
            acc_ff[u] <= '0;
         end else if (stage_valid_ff) begin
            acc_ff[u] <= sat_add(acc_ff[u], sign_rd_ff[u] ? val_neg : val_pos);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_i.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd_i.emit) begin
         rsp_unit_ff <= cmd_i.emit_unit;
         rsp_sum_ff  <= acc_ff[cmd_i.emit_unit[UIW-1:0]];
         rsp_last_ff <= cmd_i.emit_last;
      end
   end

   assign status_o.last_pending = stage_valid_ff && stage_last_ff;
   assign status_o.out_free     = !rsp_valid_ff || rsp_ready;
   assign status_o.n_out        = n_out;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_unit = rsp_unit_ff;
   assign rsp_out_sum  = rsp_sum_ff;
   assign rsp_out_last = rsp_last_ff;

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd_i.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("output word overwritten before it was taken");

   a_no_clear_while_accum: assert property (@(posedge clock) disable iff (reset)
      cmd_i.clear_acc |-> !stage_valid_ff)
      else $error("accumulator clear collides with an update");

   a_no_accept_on_close: assert property (@(posedge clock) disable iff (reset)
      cmd_i.accept |-> !(stage_valid_ff && stage_last_ff))
      else $error("input taken while the vector is closing");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      cmd_i.clear_acc |=> (acc_ff[0] == '0))
      else $error("accumulator not cleared after drain");

endmodule

// ===== rtl/binary_weight_fc_forward_top.sv =====
// Binary-weight fully connected layer, forward pass: top level.
// Instantiates bwfc_ctrl and bwfc_datapath; depends on bwfc_pkg.
//
// Usage:
//   req_* channel: one word per weight load (action 0: store sign of req_value for
//   unit req_unit_index, feature req_feature_index) or data feature (action 1).
//   rsp_* channel: one word per active output unit, in unit order, rsp_out_last on the
//   final one. csr_*: write active_inputs (index 0) / active_outputs (index 1) while idle.
//   Throughput: one request word per cycle outside the close and drain, set by the single
//   sign-memory read port and the per-unit add/subtract lanes that update all units together.
//   A data word is accumulated in the cycle after acceptance. The closing feature (index
//   active_inputs-1) passes the stage register, the controller enters drain, and the
//   output register loads the first result; the drain then gives one result per cycle
//   while rsp_ready is high. req_ready stays low until the last result is loaded.
//   A word waiting in the output register does not block new requests once the drain ends.
//   Reset: accumulators cleared, active_inputs=1024, active_outputs=64; the sign memory
//   holds no defined value until loaded.
module binary_weight_fc_forward_top #(
   parameter int OUT_DIM = bwfc_pkg::OUT_DIM_DEFAULT,
   parameter int IN_DIM  = bwfc_pkg::IN_DIM_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bwfc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bwfc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [bwfc_pkg::UNIT_W-1:0]         req_unit_index,
   input  logic [bwfc_pkg::FEAT_W-1:0]         req_feature_index,
   input  logic signed [bwfc_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bwfc_pkg::UNIT_W-1:0]         rsp_out_unit,
   output logic signed [bwfc_pkg::SUM_W-1:0]   rsp_out_sum,
   output logic                                rsp_out_last
);
   import bwfc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   bwfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   bwfc_datapath #(
      .OUT_DIM (OUT_DIM),
      .IN_DIM  (IN_DIM)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_action        (req_action),
      .req_unit_index    (req_unit_index),
      .req_feature_index (req_feature_index),
      .req_value         (req_value),
      .cmd_i             (cmd),
      .status_o          (status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_out_unit      (rsp_out_unit),
      .rsp_out_sum       (rsp_out_sum),
      .rsp_out_last      (rsp_out_last)
   );

endmodule

// ===== tb/binary_weight_fc_forward_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for binary_weight_fc_forward_top: follows csr writes, predicts every sum word
// from the accepted request words and compares it with the response channel.
// Depends on bwfc_pkg.
module binary_weight_fc_forward_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bwfc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bwfc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_action,
   input  logic [bwfc_pkg::UNIT_W-1:0]         req_unit_index,
   input  logic [bwfc_pkg::FEAT_W-1:0]         req_feature_index,
   input  logic signed [bwfc_pkg::VALUE_W-1:0] req_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [bwfc_pkg::UNIT_W-1:0]         rsp_out_unit,
   input  logic signed [bwfc_pkg::SUM_W-1:0]   rsp_out_sum,
   input  logic                                rsp_out_last,
   output int                                  mismatch_total,
   output int                                  pending_results
);
   import bwfc_pkg::*;

   localparam int     N_UNITS     = OUT_DIM_DEFAULT;
   localparam int     N_FEATS     = IN_DIM_DEFAULT;
   localparam int     MAX_REPORTS = 10;
   localparam longint ACC_MAX     = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint ACC_MIN     = -(longint'(1) <<< (SUM_W - 1));

   typedef struct {
      logic [UNIT_W-1:0]       unit;
      logic signed [SUM_W-1:0] sum;
      logic                    last;
   } sum_word_type;

   // bit u set: unit u has a negative weight for that feature
   logic [N_UNITS-1:0]      sign_rows [N_FEATS];
   logic signed [SUM_W-1:0] unit_acc [N_UNITS];
   logic [AIN_W-1:0]        cfg_inputs;
   logic [AOUT_W-1:0]       cfg_outputs;
   sum_word_type            expected_sums [$];

   function automatic void absorb_word(input logic act, input logic [UNIT_W-1:0] unit,
                                       input logic [FEAT_W-1:0] feat,
                                       input logic signed [VALUE_W-1:0] val);
      int           n_in;
      int           n_out;
      int           u;
      longint       total;
      sum_word_type w;
      n_in  = (cfg_inputs == 0) ? 1 : (cfg_inputs > N_FEATS) ? N_FEATS : int'(cfg_inputs);
      n_out = (cfg_outputs == 0) ? 1 : (cfg_outputs > N_UNITS) ? N_UNITS : int'(cfg_outputs);
      if (act == ACT_LOAD) begin
         sign_rows[feat][unit] = val[VALUE_W-1];
         return;
      end
      if (int'(feat) >= n_in) return;
      for (u = 0; u < N_UNITS; u++) begin
         total = longint'(unit_acc[u]) + (sign_rows[feat][u] ? -longint'(val) : longint'(val));
         if (total > ACC_MAX) total = ACC_MAX;
         if (total < ACC_MIN) total = ACC_MIN;
         unit_acc[u] = SUM_W'(total);
      end
      if (int'(feat) != n_in - 1) return;
      // closing feature: queue one sum per active unit, then clear every lane
      for (u = 0; u < n_out; u++) begin
         w.unit = UNIT_W'(u);
         w.sum  = unit_acc[u];
         w.last = (u == n_out - 1);
         expected_sums.push_back(w);
      end
      for (u = 0; u < N_UNITS; u++) unit_acc[u] = '0;
   endfunction

   function automatic void flag_bad_sum(input string why, input sum_word_type want);
      mismatch_total++;
      if (mismatch_total <= MAX_REPORTS) begin
         $display("%0t: sum word %s: expected unit %0d sum %0d last %0b,",
                  $time, why, want.unit, want.sum, want.last,
                  " got unit %0d sum %0d last %0b",
                  rsp_out_unit, rsp_out_sum, rsp_out_last);
      end
   endfunction

   always @(posedge clock) begin : watch
      sum_word_type want;
      int           u;
      if (reset) begin
         for (u = 0; u < N_UNITS; u++) unit_acc[u] = '0;
         cfg_inputs  = AIN_RESET;
         cfg_outputs = AOUT_RESET;
         expected_sums.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_sums.size() == 0) begin
               want = '{unit: '0, sum: '0, last: 1'b0};
               flag_bad_sum("with nothing expected", want);
            end else begin
               want = expected_sums.pop_front();
               if (rsp_out_unit !== want.unit || rsp_out_sum !== want.sum ||
                   rsp_out_last !== want.last) begin
                  flag_bad_sum("mismatch", want);
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_ACTIVE_INPUTS) cfg_inputs = csr_wdata[AIN_W-1:0];
            else if (csr_index == CSR_ACTIVE_OUTPUTS) cfg_outputs = csr_wdata[AOUT_W-1:0];
         end
         if (req_valid && req_ready) begin
            absorb_word(req_action, req_unit_index, req_feature_index, req_value);
         end
      end
      pending_results = expected_sums.size();
   end

endmodule

// ===== tb/binary_weight_fc_forward_top_tb.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for binary_weight_fc_forward_top: loads sign rows, drives feature
// words under several csr settings and pacing modes, with extreme feature values.
// Depends on bwfc_pkg, binary_weight_fc_forward_top and binary_weight_fc_forward_checker.
module binary_weight_fc_forward_top_tb;
   import bwfc_pkg::*;

   localparam int RESET_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_CYCLES     = 240;
   localparam int SETTLE_CYCLES   = 8;
   localparam int N_PHASES        = 6;
   localparam int WORDS_PER_PHASE = 16;
   localparam int N_ROWS          = 5;
   localparam int LIGHT_PCT       = 19;
   localparam int HEAVY_PCT       = 58;
   localparam logic [FEAT_W-1:0]         TOP_FEATURE = FEAT_W'(1023);
   localparam logic signed [VALUE_W-1:0] VAL_MIN     = 16'sh8000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX     = 16'sh7fff;

   logic                       clock             = 1'b0;
   logic                       reset             = 1'b1;
   logic                       csr_we            = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index         = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata         = '0;
   logic                       req_valid         = 1'b0;
   logic                       req_action        = ACT_LOAD;
   logic [UNIT_W-1:0]          req_unit_index    = '0;
   logic [FEAT_W-1:0]          req_feature_index = '0;
   logic signed [VALUE_W-1:0]  req_value         = '0;
   logic                       rsp_ready         = 1'b0;
   logic                       req_ready;
   logic                       rsp_valid;
   logic [UNIT_W-1:0]          rsp_out_unit;
   logic signed [SUM_W-1:0]    rsp_out_sum;
   logic                       rsp_out_last;

   int   mismatch_total;
   int   pending_results;
   int   send_idle_pct = LIGHT_PCT;
   int   recv_idle_pct = HEAVY_PCT;
   logic hold_request  = 1'b0;

   // only these rows get all 64 signs loaded, so no data word reads an unwritten sign
   logic [FEAT_W-1:0] loaded_rows   [N_ROWS]   = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd1023};
   int                phase_inputs  [N_PHASES] = '{4, 1, 1024, 2, 3, 2047};
   int                phase_outputs [N_PHASES] = '{64, 7, 64, 1, 40, 127};

   binary_weight_fc_forward_top dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_unit_index    (req_unit_index),
      .req_feature_index (req_feature_index),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_unit      (rsp_out_unit),
      .rsp_out_sum       (rsp_out_sum),
      .rsp_out_last      (rsp_out_last)
   );

   binary_weight_fc_forward_checker sum_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_unit_index    (req_unit_index),
      .req_feature_index (req_feature_index),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_unit      (rsp_out_unit),
      .rsp_out_sum       (rsp_out_sum),
      .rsp_out_last      (rsp_out_last),
      .mismatch_total    (mismatch_total),
      .pending_results   (pending_results)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
   end

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(11))
         0:       pick_value = VAL_MIN;
         1:       pick_value = VAL_MAX;
         2:       pick_value = '0;
         3:       pick_value = '1;
         default: pick_value = VALUE_W'($urandom);
      endcase
   endfunction

   // call at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input logic act, input logic [UNIT_W-1:0] unit,
                            input logic [FEAT_W-1:0] feat,
                            input logic signed [VALUE_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_unit_index    <= unit;
      req_feature_index <= feat;
      req_value         <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_word(input int n_in);
      int                pick;
      logic [FEAT_W-1:0] feat;
      pick = $urandom_range(99);
      if (pick < 16) begin
         send_word(ACT_LOAD, UNIT_W'($urandom), loaded_rows[$urandom_range(N_ROWS - 1)],
                   pick_value());
      end else begin
         // any loaded row (may be inactive), the closing feature, or an active low row
         if (pick < 24) feat = loaded_rows[$urandom_range(N_ROWS - 1)];
         else if (pick < 42) feat = FEAT_W'(n_in - 1);
         else feat = FEAT_W'($urandom_range(((n_in < 4) ? n_in : 4) - 1));
         send_word(ACT_DATA, UNIT_W'($urandom), feat, pick_value());
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int p;
      int k;
      int r;
      int u;
      int n_in;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < N_ROWS; r++) begin
         for (u = 0; u < 64; u++) send_word(ACT_LOAD, UNIT_W'(u), loaded_rows[r], pick_value());
      end
      // zero counts as a positive weight
      send_word(ACT_LOAD, 6'd0, 10'd0, 16'sd0);
      send_word(ACT_LOAD, 6'd1, 10'd0, -16'sd1);
      send_word(ACT_LOAD, 6'd2, 10'd0, VAL_MAX);
      send_word(ACT_LOAD, 6'd63, 10'd0, VAL_MIN);

      // reset settings: the top feature closes the vector
      send_word(ACT_DATA, 6'd63, 10'd0, VAL_MAX);
      send_word(ACT_DATA, 6'd0, 10'd1, VAL_MIN);
      send_word(ACT_DATA, 6'd21, 10'd2, 16'sd0);
      send_word(ACT_DATA, 6'd42, 10'd3, -16'sd1);
      send_word(ACT_DATA, 6'd0, TOP_FEATURE, 16'sd1);

      wait_idle();
      write_csr(CSR_ACTIVE_INPUTS, CSR_DATA_W'(3));
      write_csr(CSR_ACTIVE_OUTPUTS, CSR_DATA_W'(1));
      send_word(ACT_DATA, 6'd5, TOP_FEATURE, 16'sd5);
      send_word(ACT_DATA, 6'd5, 10'd0, 16'sd100);
      send_word(ACT_DATA, 6'd5, 10'd0, 16'sd100);
      send_word(ACT_DATA, 6'd5, 10'd2, -16'sd7);

      // zero counts clamp up to one
      wait_idle();
      write_csr(CSR_ACTIVE_INPUTS, '0);
      write_csr(CSR_ACTIVE_OUTPUTS, '0);
      send_word(ACT_DATA, 6'd9, 10'd3, -16'sd1);
      send_word(ACT_DATA, 6'd9, 10'd0, VAL_MIN);

      // oversized counts clamp down to the array size
      wait_idle();
      write_csr(CSR_ACTIVE_INPUTS, '1);
      write_csr(CSR_ACTIVE_OUTPUTS, CSR_DATA_W'(127));
      send_word(ACT_DATA, 6'd17, 10'd3, VAL_MAX);
      send_word(ACT_DATA, 6'd17, TOP_FEATURE, VAL_MIN);

      for (p = 0; p < N_PHASES; p++) begin
         wait_idle();
         write_csr(CSR_ACTIVE_INPUTS, CSR_DATA_W'(phase_inputs[p]));
         write_csr(CSR_ACTIVE_OUTPUTS, CSR_DATA_W'(phase_outputs[p]));
         send_idle_pct = (p < 2) ? LIGHT_PCT : (p < 4) ? HEAVY_PCT : 0;
         recv_idle_pct = (p < 2) ? HEAVY_PCT : (p < 4) ? LIGHT_PCT : 0;
         n_in = (phase_inputs[p] == 0) ? 1 : (phase_inputs[p] > 1024) ? 1024 : phase_inputs[p];
         if (p == 0) hold_request = 1'b1;
         for (k = 0; k < WORDS_PER_PHASE; k++) send_random_word(n_in);
      end

      // extreme feature values at full counts, then close
      wait_idle();
      write_csr(CSR_ACTIVE_INPUTS, CSR_DATA_W'(1024));
      write_csr(CSR_ACTIVE_OUTPUTS, CSR_DATA_W'(64));
      send_word(ACT_DATA, 6'd0, 10'd0, VAL_MAX);
      send_word(ACT_DATA, 6'd0, 10'd0, VAL_MIN);
      send_word(ACT_DATA, 6'd0, 10'd0, VAL_MIN);
      send_word(ACT_DATA, 6'd0, TOP_FEATURE, 16'sd0);

      wait_idle();
      if (mismatch_total == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
